/* rtl/c25enc_pkg.sv */
// Shared constants, types and pattern tables of the Code 2 of 5 encoder.
package c25enc_pkg;

  localparam int STORE_DEPTH = 128;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic [2:0] MODE_MATRIX      = 3'd0;
  localparam logic [2:0] MODE_INDUSTRIAL  = 3'd1;
  localparam logic [2:0] MODE_IATA        = 3'd2;
  localparam logic [2:0] MODE_DATALOGIC   = 3'd3;
  localparam logic [2:0] MODE_INTERLEAVED = 3'd4;
  localparam logic [2:0] MODE_ITF14       = 3'd5;
  localparam logic [2:0] MODE_LEITCODE    = 3'd6;
  localparam logic [2:0] MODE_IDENTCODE   = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_LONG = 2'd1;
  localparam logic [1:0] ST_BAD_CHAR = 2'd2;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  // What kind of word a fetch produces.
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  // Where a symbol digit comes from.
  typedef enum logic [1:0] {
    SRC_ZERO  = 2'd0,
    SRC_CHECK = 2'd1,
    SRC_STORE = 2'd2
  } src_t;

  // Fetch held between the input register and the result register.
  typedef struct packed {
    kind_t      kind;
    logic [1:0] status;
    logic [2:0] mode;
    src_t       src0;
    src_t       src1;
    logic [6:0] chk_total;
  } fetch_t;

  // Remainder by ten of a 7-bit value, by reciprocal multiplication.
  function automatic logic [3:0] mod10(input logic [6:0] x);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  r;
    prod = 15'(x) * 15'd205;
    q    = prod[14:11];
    r    = x - 7'(q) * 7'd10;
    return r[3:0];
  endfunction

  function automatic logic [7:0] length_limit(input logic [2:0] mode);
    logic [7:0] lim;
    unique case (mode)
      MODE_MATRIX, MODE_DATALOGIC:  lim = 8'd80;
      MODE_INDUSTRIAL, MODE_IATA:   lim = 8'd45;
      MODE_INTERLEAVED:             lim = 8'd89;
      MODE_ITF14, MODE_LEITCODE:    lim = 8'd13;
      default:                      lim = 8'd11;
    endcase
    return lim;
  endfunction

  // Widths are 2-bit codes, first element in the low bits: 00=1, 10=3, 11=4 modules.
  function automatic logic [11:0] matrix_pattern(input logic [3:0] d);
    logic [11:0] p;
    unique case (d)
      4'd0:    p = 12'b00_00_10_10_00_00;
      4'd1:    p = 12'b00_10_00_00_00_10;
      4'd2:    p = 12'b00_10_00_00_10_00;
      4'd3:    p = 12'b00_00_00_00_10_10;
      4'd4:    p = 12'b00_10_00_10_00_00;
      4'd5:    p = 12'b00_00_00_10_00_10;
      4'd6:    p = 12'b00_00_00_10_10_00;
      4'd7:    p = 12'b00_10_10_00_00_00;
      4'd8:    p = 12'b00_00_10_00_00_10;
      4'd9:    p = 12'b00_00_10_00_10_00;
      default: p = 12'd0;
    endcase
    return p;
  endfunction

  function automatic logic [19:0] industrial_pattern(input logic [3:0] d);
    logic [19:0] p;
    unique case (d)
      4'd0:    p = 20'b00_00_00_10_00_10_00_00_00_00;
      4'd1:    p = 20'b00_10_00_00_00_00_00_00_00_10;
      4'd2:    p = 20'b00_10_00_00_00_00_00_10_00_00;
      4'd3:    p = 20'b00_00_00_00_00_00_00_10_00_10;
      4'd4:    p = 20'b00_10_00_00_00_10_00_00_00_00;
      4'd5:    p = 20'b00_00_00_00_00_10_00_00_00_10;
      4'd6:    p = 20'b00_00_00_00_00_10_00_10_00_00;
      4'd7:    p = 20'b00_10_00_10_00_00_00_00_00_00;
      4'd8:    p = 20'b00_00_00_10_00_00_00_00_00_10;
      4'd9:    p = 20'b00_00_00_10_00_00_00_10_00_00;
      default: p = 20'd0;
    endcase
    return p;
  endfunction

  function automatic logic [9:0] interleaved_digit(input logic [3:0] d);
    logic [9:0] p;
    unique case (d)
      4'd0:    p = 10'b00_10_10_00_00;
      4'd1:    p = 10'b10_00_00_00_10;
      4'd2:    p = 10'b10_00_00_10_00;
      4'd3:    p = 10'b00_00_00_10_10;
      4'd4:    p = 10'b10_00_10_00_00;
      4'd5:    p = 10'b00_00_10_00_10;
      4'd6:    p = 10'b00_00_10_10_00;
      4'd7:    p = 10'b10_10_00_00_00;
      4'd8:    p = 10'b00_10_00_00_10;
      4'd9:    p = 10'b00_10_00_10_00;
      default: p = 10'd0;
    endcase
    return p;
  endfunction

  // The first digit sets the bars, the second digit the spaces between them.
  function automatic logic [19:0] interleave_pair(input logic [3:0] d0, input logic [3:0] d1);
    logic [9:0]  bars;
    logic [9:0]  spcs;
    logic [19:0] p;
    bars = interleaved_digit(d0);
    spcs = interleaved_digit(d1);
    for (int j = 0; j < 5; j++) begin
      p[4*j +: 2]     = bars[2*j +: 2];
      p[4*j + 2 +: 2] = spcs[2*j +: 2];
    end
    return p;
  endfunction

  // Source of one symbol digit at position p.
  function automatic src_t digit_source(input logic [7:0] p, input logic [7:0] lead,
                                        input logic [7:0] len, input logic has_chk);
    src_t s;
    if (p < lead) begin
      s = SRC_ZERO;
    end else if (has_chk && (p == len - 8'd1)) begin
      s = SRC_CHECK;
    end else begin
      s = SRC_STORE;
    end
    return s;
  endfunction

endpackage

/* rtl/two_of_five_barcode_encoder_top.sv */
// Code 2 of 5 barcode encoder: digit store, fetch decode and pattern output.
// A fetch passes through the input register and then the result register, which presents
// its result word on the master side. Loads give no result word.
// Loads and fetches alike go at one transfer per cycle while the result side does not stall.
// Reset (rst, synchronous, active high) clears the count, flags, sums, word index and the
// pipeline valid bits, and sets symbology_mode to interleaved. The digit store is not cleared.
module two_of_five_barcode_encoder_top (
  input  logic        clk,
  input  logic        rst,
  // Configuration: symbology_mode write.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tuser,   // [0] req_type
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [19:0] pattern, [23:20] element_count
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast    // last_word
);

  // Configuration register.
  logic [2:0] mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= c25enc_pkg::MODE_INTERLEAVED;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  // Symbol state. The parity sums hold the digit totals of even and odd load positions.
  logic [7:0] char_count;
  logic       overflow;
  logic       bad_char;
  logic [6:0] sum0;
  logic [6:0] sum1;
  logic [6:0] emit_index;

  // Digit store, one write port for loads and two read ports for fetches.
  logic [3:0] digit_store [c25enc_pkg::STORE_DEPTH];
  logic [3:0] rd0;
  logic [3:0] rd1;

  // Input register stage and result register.
  logic                 s1_valid;
  c25enc_pkg::fetch_t   s1;
  logic                 s1_adv;
  logic                 o_valid;
  logic [1:0]           o_status;
  logic [19:0]          o_pattern;
  logic [3:0]           o_count;
  logic                 o_last;

  // Handshake. A fetch moves into the input register when that register is empty or empties
  // into the result register in the same cycle; transfers stall only on result back-pressure.
  logic in_acc;
  logic load_acc;
  logic fetch_acc;

  assign s1_adv        = s1_valid && (!o_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign load_acc      = in_acc && (s_axis_tuser == c25enc_pkg::REQ_LOAD);
  assign fetch_acc     = in_acc && (s_axis_tuser == c25enc_pkg::REQ_FETCH);

  // Load decode: a non-digit is stored as zero and flagged.
  logic       is_digit;
  logic [7:0] char_off;
  logic [3:0] load_digit;
  logic       has_room;
  logic       store_we;

  assign is_digit   = (s_axis_tdata >= 8'd48) && (s_axis_tdata <= 8'd57);
  assign char_off   = s_axis_tdata - 8'd48;
  assign load_digit = is_digit ? char_off[3:0] : 4'd0;
  assign has_room   = ({1'b0, char_count} < 9'(c25enc_pkg::STORE_DEPTH))
                      && (char_count != 8'hFF);
  assign store_we   = load_acc && has_room;

  // Fetch decode. Symbol length, leading zero padding and the number of data words
  // all follow from the current mode and character count.
  logic       narrow;
  logic       has_chk;
  logic       too_long;
  logic [7:0] sym_len;
  logic [7:0] lead;
  logic [7:0] words;
  logic [6:0] item;
  logic [7:0] pos0;
  logic [7:0] pos1;
  logic [7:0] off0;
  logic [7:0] off1;
  logic [6:0] even_sum;
  logic [6:0] odd_sum;
  logic [3:0] even_mod;
  logic [3:0] odd_mod;
  c25enc_pkg::fetch_t s1_next;

  assign narrow   = !mode[2];
  assign has_chk  = mode[2] && (mode[1] || mode[0]);
  assign too_long = overflow || (char_count > c25enc_pkg::length_limit(mode));

  always_comb begin
    unique case (mode)
      c25enc_pkg::MODE_INTERLEAVED:                     sym_len = char_count
                                                                  + {7'd0, char_count[0]};
      c25enc_pkg::MODE_ITF14, c25enc_pkg::MODE_LEITCODE: sym_len = 8'd14;
      c25enc_pkg::MODE_IDENTCODE:                       sym_len = 8'd12;
      default:                                          sym_len = char_count;
    endcase
  end

  assign lead  = sym_len - char_count - {7'd0, has_chk};
  assign words = narrow ? sym_len : {1'b0, sym_len[7:1]};
  assign item  = emit_index - 7'd1;
  assign pos0  = narrow ? {1'b0, item} : {item, 1'b0};
  assign pos1  = {item, 1'b1};
  assign off0  = pos0 - lead;
  assign off1  = pos1 - lead;

  // Check digit weights: the position of a load relative to the end sets its weight.
  assign even_sum = char_count[0] ? sum0 : sum1;
  assign odd_sum  = char_count[0] ? sum1 : sum0;
  assign even_mod = c25enc_pkg::mod10(even_sum);
  assign odd_mod  = c25enc_pkg::mod10(odd_sum);

  always_comb begin
    s1_next.mode   = mode;
    s1_next.status = c25enc_pkg::ST_OK;
    s1_next.src0   = c25enc_pkg::digit_source(pos0, lead, sym_len, has_chk);
    s1_next.src1   = c25enc_pkg::digit_source(pos1, lead, sym_len, has_chk);
    if (mode == c25enc_pkg::MODE_ITF14) begin
      s1_next.chk_total = 7'(even_mod) * 7'd3 + 7'(odd_mod);
    end else begin
      s1_next.chk_total = 7'(even_mod) * 7'd4 + 7'(odd_mod) * 7'd9;
    end
    if (too_long) begin
      s1_next.kind   = c25enc_pkg::KIND_ERROR;
      s1_next.status = c25enc_pkg::ST_TOO_LONG;
    end else if (bad_char) begin
      s1_next.kind   = c25enc_pkg::KIND_ERROR;
      s1_next.status = c25enc_pkg::ST_BAD_CHAR;
    end else if (emit_index == 7'd0) begin
      s1_next.kind = c25enc_pkg::KIND_START;
    end else if ({1'b0, emit_index} <= words) begin
      s1_next.kind = c25enc_pkg::KIND_DATA;
    end else begin
      s1_next.kind = c25enc_pkg::KIND_STOP;
    end
  end

  // A stop or error word ends the symbol and returns the state to its cleared form.
  logic ends_symbol;
  assign ends_symbol = (s1_next.kind == c25enc_pkg::KIND_ERROR)
                       || (s1_next.kind == c25enc_pkg::KIND_STOP);

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= 8'd0;
      overflow   <= 1'b0;
      bad_char   <= 1'b0;
      sum0       <= 7'd0;
      sum1       <= 7'd0;
      emit_index <= 7'd0;
    end else if (fetch_acc) begin
      if (ends_symbol) begin
        char_count <= 8'd0;
        overflow   <= 1'b0;
        bad_char   <= 1'b0;
        sum0       <= 7'd0;
        sum1       <= 7'd0;
        emit_index <= 7'd0;
      end else begin
        emit_index <= emit_index + 7'd1;
      end
    end else if (load_acc) begin
      if (!is_digit) begin
        bad_char <= 1'b1;
      end
      if (has_room) begin
        char_count <= char_count + 8'd1;
        if (char_count[0]) begin
          sum1 <= sum1 + {3'd0, load_digit};
        end else begin
          sum0 <= sum0 + {3'd0, load_digit};
        end
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  // Store write and registered reads. Read data only moves with a fetch, so a held
  // fetch keeps its digits while later loads write the store.
  always_ff @(posedge clk) begin
    if (store_we) begin
      digit_store[char_count[c25enc_pkg::ADDR_W-1:0]] <= load_digit;
    end
    if (fetch_acc) begin
      rd0 <= digit_store[off0[c25enc_pkg::ADDR_W-1:0]];
      rd1 <= digit_store[off1[c25enc_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= fetch_acc;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_acc) begin
      s1 <= s1_next;
    end
  end

  // Result stage: finish the check digit, pick the digits and look up the widths.
  logic [3:0]  chk_rem;
  logic [3:0]  chk_digit;
  logic [3:0]  dig0;
  logic [3:0]  dig1;
  logic [1:0]  res_status;
  logic [19:0] res_pattern;
  logic [3:0]  res_count;
  logic        res_last;

  assign chk_rem   = c25enc_pkg::mod10(s1.chk_total);
  assign chk_digit = (chk_rem == 4'd0) ? 4'd0 : 4'd10 - chk_rem;

  always_comb begin
    unique case (s1.src0)
      c25enc_pkg::SRC_CHECK: dig0 = chk_digit;
      c25enc_pkg::SRC_STORE: dig0 = rd0;
      default:               dig0 = 4'd0;
    endcase
    unique case (s1.src1)
      c25enc_pkg::SRC_CHECK: dig1 = chk_digit;
      c25enc_pkg::SRC_STORE: dig1 = rd1;
      default:               dig1 = 4'd0;
    endcase
  end

  always_comb begin
    res_status  = s1.status;
    res_pattern = 20'd0;
    res_count   = 4'd0;
    res_last    = 1'b0;
    unique case (s1.kind)
      c25enc_pkg::KIND_START: begin
        unique case (s1.mode)
          c25enc_pkg::MODE_MATRIX: begin
            res_pattern = 20'b00_00_00_00_00_11;
            res_count   = 4'd6;
          end
          c25enc_pkg::MODE_INDUSTRIAL: begin
            res_pattern = 20'b00_00_00_10_00_10;
            res_count   = 4'd6;
          end
          default: begin
            res_pattern = 20'd0;
            res_count   = 4'd4;
          end
        endcase
      end
      c25enc_pkg::KIND_DATA: begin
        unique case (s1.mode)
          c25enc_pkg::MODE_MATRIX, c25enc_pkg::MODE_DATALOGIC: begin
            res_pattern = {8'd0, c25enc_pkg::matrix_pattern(dig0)};
            res_count   = 4'd6;
          end
          c25enc_pkg::MODE_INDUSTRIAL, c25enc_pkg::MODE_IATA: begin
            res_pattern = c25enc_pkg::industrial_pattern(dig0);
            res_count   = 4'd10;
          end
          default: begin
            res_pattern = c25enc_pkg::interleave_pair(dig0, dig1);
            res_count   = 4'd10;
          end
        endcase
      end
      c25enc_pkg::KIND_STOP: begin
        res_last = 1'b1;
        unique case (s1.mode)
          c25enc_pkg::MODE_MATRIX: begin
            res_pattern = 20'b00_00_00_00_11;
            res_count   = 4'd5;
          end
          c25enc_pkg::MODE_INDUSTRIAL: begin
            res_pattern = 20'b10_00_00_00_10;
            res_count   = 4'd5;
          end
          default: begin
            res_pattern = 20'b00_00_10;
            res_count   = 4'd3;
          end
        endcase
      end
      default: begin
        res_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_adv) begin
      o_valid <= 1'b1;
    end else if (m_axis_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_status  <= res_status;
      o_pattern <= res_pattern;
      o_count   <= res_count;
      o_last    <= res_last;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {o_count, o_pattern};
  assign m_axis_tuser  = o_status;
  assign m_axis_tlast  = o_last;

  // A fetch always lands in the input register.
  a_fetch_lands : assert property (@(posedge clk) disable iff (rst)
    fetch_acc |=> s1_valid)
    else $error("accepted fetch did not reach the input register");

  // Ending a symbol leaves the state cleared.
  a_clear_after_end : assert property (@(posedge clk) disable iff (rst)
    (fetch_acc && ends_symbol) |=> (char_count == 8'd0) && (emit_index == 7'd0)
                                   && !overflow && !bad_char)
    else $error("state not cleared after stop or error word");

  // An error word is a bare last word.
  a_error_word : assert property (@(posedge clk) disable iff (rst)
    (o_valid && (o_status != c25enc_pkg::ST_OK)) |-> o_last && (o_count == 4'd0)
                                                     && (o_pattern == 20'd0))
    else $error("error word carries a pattern");

  // Words never claim more than ten widths.
  a_count_range : assert property (@(posedge clk) disable iff (rst)
    o_valid |-> (o_count <= 4'd10))
    else $error("element count out of range");

endmodule

/* tb/c25_word_checker.sv */
// Scoreboard that predicts and checks every word of the Code 2 of 5 encoder result stream.
`timescale 1ns / 100ps

module c25_word_checker
  import c25enc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tuser,   // [0] req_type
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // [19:0] pattern, [23:20] element_count
  input  logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        m_axis_tlast,   // last_word
  output int          mismatches,
  output int          outstanding
);

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Element width codes as they appear in the pattern field.
  localparam logic [1:0] WIDTH_1 = 2'd0;
  localparam logic [1:0] WIDTH_2 = 2'd1;
  localparam logic [1:0] WIDTH_3 = 2'd2;
  localparam logic [1:0] WIDTH_4 = 2'd3;

  typedef enum { FAM_MATRIX, FAM_INDUSTRIAL, FAM_INTERLEAVED } family_t;

  typedef struct {
    logic [1:0]  status;
    logic [19:0] pattern;
    logic [3:0]  elements;
    logic        last;
  } bar_word_t;

  bar_word_t   expected_words [$];
  int          fail_count = 0;

  // Encoder state as the checker sees it.
  logic [2:0]  sym_mode;
  logic [3:0]  digit_mem [STORE_DEPTH];
  int unsigned stored;
  logic        overflowed;
  logic        bad_seen;
  logic [6:0]  pos_sums [2];
  int unsigned word_idx;

  // Bar and space widths of one digit, narrow as 1 and wide as 3, first element first.
  function automatic string digit_widths(input family_t fam, input int unsigned d);
    string w;
    w = "";
    case (fam)
      FAM_MATRIX:
        case (d)
          0: w = "113311"; 1: w = "311131"; 2: w = "131131"; 3: w = "331111";
          4: w = "113131"; 5: w = "313111"; 6: w = "133111"; 7: w = "111331";
          8: w = "311311"; default: w = "131311";
        endcase
      FAM_INDUSTRIAL:
        case (d)
          0: w = "1111313111"; 1: w = "3111111131"; 2: w = "1131111131";
          3: w = "3131111111"; 4: w = "1111311131"; 5: w = "3111311111";
          6: w = "1131311111"; 7: w = "1111113131"; 8: w = "3111113111";
          default: w = "1131113111";
        endcase
      default:
        case (d)
          0: w = "11331"; 1: w = "31113"; 2: w = "13113"; 3: w = "33111";
          4: w = "11313"; 5: w = "31311"; 6: w = "13311"; 7: w = "11133";
          8: w = "31131"; default: w = "13131";
        endcase
    endcase
    return w;
  endfunction

  function automatic logic [19:0] pack_widths(input string w, output logic [3:0] n);
    logic [19:0] v;
    int          k;
    v = '0;
    for (k = 0; k < w.len() && k < 10; k++) begin
      case (w[k])
        "2":     v[2*k +: 2] = WIDTH_2;
        "3":     v[2*k +: 2] = WIDTH_3;
        "4":     v[2*k +: 2] = WIDTH_4;
        default: v[2*k +: 2] = WIDTH_1;
      endcase
    end
    n = 4'(k);
    return v;
  endfunction

  function automatic int unsigned digit_limit(input logic [2:0] m);
    case (m)
      MODE_MATRIX, MODE_DATALOGIC: return 80;
      MODE_INDUSTRIAL, MODE_IATA:  return 45;
      MODE_INTERLEAVED:            return 89;
      MODE_ITF14, MODE_LEITCODE:   return 13;
      default:                     return 11;
    endcase
  endfunction

  task automatic clear_symbol();
    stored      = 0;
    overflowed  = 1'b0;
    bad_seen    = 1'b0;
    pos_sums[0] = '0;
    pos_sums[1] = '0;
    word_idx    = 0;
  endtask

  task automatic push_word(input logic [1:0] st, input logic [19:0] pat,
                           input logic [3:0] cnt, input logic last);
    bar_word_t w;
    w.status   = st;
    w.pattern  = pat;
    w.elements = cnt;
    w.last     = last;
    expected_words.push_back(w);
  endtask

  // Apply one accepted request to the state and queue the word a fetch produces.
  task automatic take_request(input logic rq, input logic [7:0] ch);
    int unsigned n, len, lead, words, chk, total, even_sum, odd_sum, item, parts, p, j;
    int unsigned dig [2];
    logic [3:0]  d, cnt;
    logic [19:0] pat;
    logic        has_chk;
    string       bars, spaces, sym, start_w, stop_w;
    family_t     fam;

    if (rq != REQ_FETCH) begin
      d = 4'd0;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) d = 4'(ch - CHAR_ZERO);
      else bad_seen = 1'b1;
      if (stored < STORE_DEPTH && stored < 255) begin
        digit_mem[stored]    = d;
        pos_sums[stored % 2] = pos_sums[stored % 2] + 7'(d);
        stored++;
      end else begin
        overflowed = 1'b1;
      end
      return;
    end

    // The length error wins over a bad character.
    if (overflowed || stored > digit_limit(sym_mode)) begin
      push_word(ST_TOO_LONG, '0, '0, 1'b1);
      clear_symbol();
      return;
    end
    if (bad_seen) begin
      push_word(ST_BAD_CHAR, '0, '0, 1'b1);
      clear_symbol();
      return;
    end

    n       = stored;
    has_chk = (sym_mode >= MODE_ITF14);
    case (sym_mode)
      MODE_INTERLEAVED:          len = n + (n % 2);
      MODE_ITF14, MODE_LEITCODE: len = 14;
      MODE_IDENTCODE:            len = 12;
      default:                   len = n;
    endcase
    lead = len - n - (has_chk ? 1 : 0);
    chk  = 0;
    if (has_chk) begin
      // Sums by load position, taken relative to the digit next to the check digit.
      even_sum = pos_sums[(n + 1) % 2];
      odd_sum  = pos_sums[n % 2];
      total    = (sym_mode == MODE_ITF14) ? 3 * even_sum + odd_sum
                                          : 4 * even_sum + 9 * odd_sum;
      chk      = (10 - total % 10) % 10;
    end
    words = (sym_mode < MODE_INTERLEAVED) ? len : len / 2;

    case (sym_mode)
      MODE_MATRIX:     begin start_w = "411111"; stop_w = "41111"; end
      MODE_INDUSTRIAL: begin start_w = "313111"; stop_w = "31113"; end
      default:         begin start_w = "1111";   stop_w = "311";   end
    endcase

    if (word_idx == 0) begin
      pat = pack_widths(start_w, cnt);
      push_word(ST_OK, pat, cnt, 1'b0);
      word_idx = 1;
    end else if (word_idx <= words) begin
      item  = word_idx - 1;
      parts = (sym_mode < MODE_INTERLEAVED) ? 1 : 2;
      for (j = 0; j < parts; j++) begin
        p = (parts == 1) ? item : 2 * item + j;
        if (p < lead) dig[j] = 0;
        else if (has_chk && p == len - 1) dig[j] = chk;
        else dig[j] = digit_mem[p - lead] % 10;
      end
      if (sym_mode == MODE_MATRIX || sym_mode == MODE_DATALOGIC) fam = FAM_MATRIX;
      else if (sym_mode == MODE_INDUSTRIAL || sym_mode == MODE_IATA) fam = FAM_INDUSTRIAL;
      else fam = FAM_INTERLEAVED;
      if (fam == FAM_INTERLEAVED) begin
        // The first digit sets the bars and the second the spaces between them.
        bars   = digit_widths(fam, dig[0]);
        spaces = digit_widths(fam, dig[1]);
        sym    = "";
        for (j = 0; j < 5; j++) sym = {sym, bars.substr(j, j), spaces.substr(j, j)};
      end else begin
        sym = digit_widths(fam, dig[0]);
      end
      pat = pack_widths(sym, cnt);
      push_word(ST_OK, pat, cnt, 1'b0);
      word_idx = (word_idx + 1) % 128;
    end else begin
      pat = pack_widths(stop_w, cnt);
      push_word(ST_OK, pat, cnt, 1'b1);
      clear_symbol();
    end
  endtask

  always @(posedge clk) begin
    bar_word_t want;
    if (rst) begin
      sym_mode = MODE_INTERLEAVED;
      clear_symbol();
      expected_words.delete();
    end else begin
      if (cfg_we) sym_mode = cfg_wdata;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word: pattern %h status %0d", m_axis_tdata[19:0],
                 m_axis_tuser);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (m_axis_tuser !== want.status) begin
            $error("status expected %0d got %0d", want.status, m_axis_tuser);
            fail_count++;
          end
          if (m_axis_tdata[19:0] !== want.pattern) begin
            $error("pattern expected %h got %h", want.pattern, m_axis_tdata[19:0]);
            fail_count++;
          end
          if (m_axis_tdata[23:20] !== want.elements) begin
            $error("element_count expected %0d got %0d", want.elements, m_axis_tdata[23:20]);
            fail_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_word expected %0d got %0d", want.last, m_axis_tlast);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) take_request(s_axis_tuser, s_axis_tdata);
    end
    outstanding <= expected_words.size();
    mismatches  <= fail_count;
  end

endmodule

/* tb/testbench.sv */
// Top of the Code 2 of 5 encoder testbench: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 100ps

module testbench;
  import c25enc_pkg::*;

  // The outstanding count from the scoreboard is registered and lags the result stream,
  // so drain() waits on past it before the mode register is touched.
  localparam int DRAIN_CYCLES   = 4;
  // Longest stretch without any transfer before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 100;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef enum { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_profile_t;

  logic        clk;
  logic        rst           = 1'b1;
  logic        cfg_we        = 1'b0;
  logic [2:0]  cfg_wdata     = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;    // [7:0] char_code
  logic        s_axis_tuser  = 1'b0;  // [0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;          // [19:0] pattern, [23:20] element_count
  logic [1:0]  m_axis_tuser;          // [1:0] status
  logic        m_axis_tlast;          // last_word

  int          mismatches;
  int          outstanding;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct    = 0;
  int unsigned items_sent   = 0;
  int unsigned idle_cycles  = 0;
  logic [2:0]  cur_mode     = MODE_INTERLEAVED;

  logic [2:0]  phase_modes [PHASES] = '{MODE_MATRIX, MODE_IDENTCODE, MODE_INTERLEAVED,
                                        MODE_INDUSTRIAL, MODE_IATA, MODE_DATALOGIC,
                                        MODE_ITF14, MODE_LEITCODE, MODE_IDENTCODE,
                                        MODE_MATRIX, MODE_ITF14, MODE_INTERLEAVED};

  two_of_five_barcode_encoder_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // The scoreboard watches both streams and the mode writes on its own.
  c25_word_checker scoreboard (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver drops tready at random, as often as the current phase asks.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Any transfer on either side restarts the count; a long silence means a hang.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Offers one request and returns once it has been taken. The valid is only
  // lowered for a gap, so back-to-back transfers keep it high throughout.
  task automatic send_item(input logic rq, input logic [7:0] ch);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rq;
    s_axis_tdata  <= ch;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // Waits until every expected word has come back and the pipeline has emptied.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int unsigned digit_limit(input logic [2:0] m);
    case (m)
      MODE_MATRIX, MODE_DATALOGIC: return 80;
      MODE_INDUSTRIAL, MODE_IATA:  return 45;
      MODE_INTERLEAVED:            return 89;
      MODE_ITF14, MODE_LEITCODE:   return 13;
      default:                     return 11;
    endcase
  endfunction

  // One symbol: a run of loads followed by the fetches that read it out. Most
  // symbols are clean and fit the mode; some run past the length limit, fill the
  // store, carry a non-digit, get cut short, or have stray requests mixed in.
  task automatic emit_symbol();
    int unsigned lim, n, roll, words, fetches, i;
    int          bad_at;
    logic [7:0]  ch;
    lim  = digit_limit(cur_mode);
    roll = $urandom_range(199);
    if (roll < 110)      n = $urandom_range(lim < 12 ? lim : 12);
    else if (roll < 155) n = $urandom_range(lim);
    else if (roll < 175) n = lim;
    else if (roll < 195) n = lim + 1 + $urandom_range(2);
    else                 n = STORE_DEPTH + 1 + $urandom_range(1);
    bad_at = ($urandom_range(9) == 0 && n > 0) ? int'($urandom_range(n - 1)) : -1;

    for (i = 0; i < n; i++) begin
      if (i == bad_at) begin
        do ch = 8'($urandom_range(255)); while (ch >= CHAR_ZERO && ch <= CHAR_NINE);
      end else begin
        ch = CHAR_ZERO + 8'($urandom_range(9));
      end
      send_item(REQ_LOAD, ch);
      if ($urandom_range(29) == 0) send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
    end

    case (cur_mode)
      MODE_INTERLEAVED:          words = (n + 1) / 2;
      MODE_ITF14, MODE_LEITCODE: words = 7;
      MODE_IDENTCODE:            words = 6;
      default:                   words = n;
    endcase
    fetches = (bad_at >= 0 || n > lim) ? 1 : words + 2;
    if ($urandom_range(19) == 0) fetches = $urandom_range(fetches);
    for (i = 0; i < fetches; i++) begin
      // The char field is don't-care on a fetch, so it carries random bits.
      send_item(REQ_FETCH, 8'($urandom_range(255)));
      if ($urandom_range(39) == 0) send_item(REQ_LOAD, CHAR_ZERO + 8'($urandom_range(9)));
    end
  endtask

  initial begin
    int phase;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part in the reset mode (interleaved).
    // Empty store: start word straight into stop word.
    send_item(REQ_FETCH, 8'h00);
    send_item(REQ_FETCH, 8'hFF);
    // Odd digit count gets a leading zero: pairs 00 and 95.
    send_item(REQ_LOAD, CHAR_ZERO);
    send_item(REQ_LOAD, CHAR_NINE);
    send_item(REQ_LOAD, CHAR_ZERO + 8'd5);
    repeat (4) send_item(REQ_FETCH, 8'h00);
    // Characters just outside the digit range give a bad character word.
    send_item(REQ_LOAD, CHAR_ZERO - 8'd1);
    send_item(REQ_LOAD, CHAR_NINE + 8'd1);
    send_item(REQ_FETCH, 8'hFF);
    // Extremes of the char field: both are non-digits.
    send_item(REQ_LOAD, 8'hFF);
    send_item(REQ_LOAD, 8'h00);
    send_item(REQ_FETCH, 8'h00);
    // A good digit after the error word proves the symbol state was cleared.
    send_item(REQ_LOAD, CHAR_ZERO + 8'd7);
    repeat (3) send_item(REQ_FETCH, 8'h00);

    // Random part: each phase picks a mode and an idling profile, with the mode
    // written only after the previous phase has fully drained.
    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      case (idle_profile_t'(phase % 4))
        IDLE_NONE:     begin send_gap_pct = 0;  stall_pct = 0;  end
        IDLE_SENDER:   begin send_gap_pct = 73; stall_pct = 0;  end
        IDLE_RECEIVER: begin send_gap_pct = 0;  stall_pct = 73; end
        default:       begin send_gap_pct = 38; stall_pct = 38; end
      endcase
      cur_mode = phase_modes[phase];
      cfg_we    <= 1'b1;
      cfg_wdata <= cur_mode;
      @(posedge clk);
      cfg_we    <= 1'b0;
      while (items_sent < (phase + 1) * PHASE_ITEMS + 20) emit_symbol();
    end

    drain();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* two_of_five_barcode_encoder_top.f */
rtl/c25enc_pkg.sv
rtl/two_of_five_barcode_encoder_top.sv
tb/c25_word_checker.sv
tb/testbench.sv
